// ===== rtl/ipc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared types and constants of the irrigation pump controller: event kinds,
// pump states, status codes, register indexes, reset values and payloads.
// ----------------------------------------------------------------------------
package ipc_pkg;

   // widths
   localparam int unsigned TimeWidth   = 32;
   localparam int unsigned MoistWidth  = 10;
   localparam int unsigned FlowWidth   = 16;
   localparam int unsigned CountWidth  = 32;
   localparam int unsigned VolumeWidth = 64;
   localparam int unsigned ProdWidth   = TimeWidth + FlowWidth;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDatWidth = 32;

   // register reset values
   localparam logic [TimeWidth-1:0]  MaxRunReset     = 32'd60000;
   localparam logic [TimeWidth-1:0]  MinCooldownReset = 32'd300000;
   localparam logic [MoistWidth-1:0] StartThreshReset = 10'd400;
   localparam logic [MoistWidth-1:0] StopThreshReset  = 10'd600;
   localparam logic [FlowWidth-1:0]  FlowRateReset    = 16'd2560;
   localparam logic                  ActiveLowReset   = 1'b0;

   // event kinds
   typedef enum logic [1:0] {
      KIND_EVALUATE   = 2'd0,
      KIND_MANUAL_ON  = 2'd1,
      KIND_MANUAL_OFF = 2'd2,
      KIND_UNUSED     = 2'd3
   } kind_type;

   // pump states
   typedef enum logic [1:0] {
      PUMP_OFF  = 2'd0,
      PUMP_ON   = 2'd1,
      PUMP_LOCK = 2'd2
   } pump_state_type;

   // status codes
   typedef enum logic [3:0] {
      STATUS_RESERVOIR_LOCK = 4'd0,
      STATUS_RUNTIME_LOCK   = 4'd1,
      STATUS_TARGET_REACHED = 4'd2,
      STATUS_IRRIGATING     = 4'd3,
      STATUS_COOLDOWN       = 4'd4,
      STATUS_TRIGGERED      = 4'd5,
      STATUS_IDLE           = 4'd6,
      STATUS_MANUAL_ON      = 4'd7,
      STATUS_MANUAL_OFF     = 4'd8
   } status_type;

   // configuration register indexes
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_MAX_RUN_MS      = 3'd0,
      CSR_MIN_COOLDOWN_MS = 3'd1,
      CSR_START_THRESHOLD = 3'd2,
      CSR_STOP_THRESHOLD  = 3'd3,
      CSR_FLOW_RATE       = 3'd4,
      CSR_ACTIVE_LOW      = 3'd5
   } csr_index_type;

   // input item
   typedef struct packed {
      logic [1:0]            kind;
      logic [TimeWidth-1:0]  now_ms;
      logic                  reservoir_safe;
      logic [MoistWidth-1:0] soil_moisture;
   } req_type;

   // result item
   typedef struct packed {
      logic                   pin_level;
      logic                   pump_running;
      logic [1:0]             pump_state;
      logic [3:0]             status_code;
      logic [TimeWidth-1:0]   run_duration_ms;
      logic [CountWidth-1:0]  session_total;
      logic [VolumeWidth-1:0] dispensed_total;
   } rsp_type;

endpackage

// ===== rtl/irrigation_pump_controller.sv =====
// An accepted item passes the input, middle and output registers before rsp_valid.
// Throughput: one item per cycle while rsp_stall is low; the control decision
// takes one stage and the volume product is added to the 64-bit total in the
// following stage. A held rsp_stall fills the three stages, then raises req_stall.
// Reset: synchronous, active high; registers return to their default values,
// the pump is off, status idle, counters and volume total are zero.
// ----------------------------------------------------------------------------
// irrigation_pump_controller
// Evaluates pump events against reservoir, runtime, moisture and cooldown
// rules, counts automatic sessions and accumulates dispensed volume.
// ----------------------------------------------------------------------------
module irrigation_pump_controller
   import ipc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CsrDatWidth-1:0] csr_wdata
);

   // configuration registers
   logic [TimeWidth-1:0]  max_run_ff, min_cooldown_ff;
   logic [MoistWidth-1:0] start_thresh_ff, stop_thresh_ff;
   logic [FlowWidth-1:0]  flow_rate_ff;
   logic                  active_low_ff;

   // control state
   logic                  running_ff, running_in;
   logic [TimeWidth-1:0]  start_ff, start_in;
   logic [TimeWidth-1:0]  last_stop_ff, last_stop_in;
   logic [CountWidth-1:0] count_ff, count_in;
   pump_state_type        state_ff, state_in;
   status_type            status_ff, status_in;
   logic [VolumeWidth-1:0] volume_ff, volume_in;

   // pipeline registers
   logic                  in_valid_ff;
   req_type               in_data_ff;
   logic                  mid_valid_ff;
   rsp_type               mid_data_ff, mid_data_in;
   logic                  mid_add_ff, mid_add_in;
   logic [ProdWidth-1:0]  mid_prod_ff, mid_prod_in;
   logic                  out_valid_ff;
   rsp_type               out_data_ff, out_data_in;

   // decision helpers
   logic [TimeWidth-1:0]  run_ms;
   logic [TimeWidth-1:0]  since_stop;
   logic                  in_cooldown;
   logic [VolumeWidth:0]  vol_sum;

   // stage advance
   logic out_free, mid_adv, in_adv;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign mid_adv   = mid_valid_ff && out_free;
   assign in_adv    = in_valid_ff && (!mid_valid_ff || mid_adv);
   assign req_stall = in_valid_ff && !in_adv;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_run_ff      <= MaxRunReset;
         min_cooldown_ff <= MinCooldownReset;
         start_thresh_ff <= StartThreshReset;
         stop_thresh_ff  <= StopThreshReset;
         flow_rate_ff    <= FlowRateReset;
         active_low_ff   <= ActiveLowReset;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_RUN_MS:      max_run_ff      <= csr_wdata;
            CSR_MIN_COOLDOWN_MS: min_cooldown_ff <= csr_wdata;
            CSR_START_THRESHOLD: start_thresh_ff <= csr_wdata[MoistWidth-1:0];
            CSR_STOP_THRESHOLD:  stop_thresh_ff  <= csr_wdata[MoistWidth-1:0];
            CSR_FLOW_RATE:       flow_rate_ff    <= csr_wdata[FlowWidth-1:0];
            CSR_ACTIVE_LOW:      active_low_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // rule evaluation for the item in the input register
   assign run_ms      = in_data_ff.now_ms - start_ff;
   assign since_stop  = in_data_ff.now_ms - last_stop_ff;
   assign in_cooldown = (since_stop < min_cooldown_ff) && (last_stop_ff != '0);

   always_comb begin
      running_in   = running_ff;
      start_in     = start_ff;
      last_stop_in = last_stop_ff;
      count_in     = count_ff;
      state_in     = state_ff;
      status_in    = status_ff;
      mid_add_in   = 1'b0;
      case (kind_type'(in_data_ff.kind))
         KIND_EVALUATE: begin
            if (!in_data_ff.reservoir_safe) begin
               if (running_ff) begin
                  running_in   = 1'b0;
                  last_stop_in = in_data_ff.now_ms;
               end
               state_in  = PUMP_LOCK;
               status_in = STATUS_RESERVOIR_LOCK;
            end else if (running_ff) begin
               if (run_ms >= max_run_ff) begin
                  running_in   = 1'b0;
                  last_stop_in = in_data_ff.now_ms;
                  state_in     = PUMP_LOCK;
                  status_in    = STATUS_RUNTIME_LOCK;
                  mid_add_in   = 1'b1;
               end else if (in_data_ff.soil_moisture >= stop_thresh_ff) begin
                  running_in   = 1'b0;
                  last_stop_in = in_data_ff.now_ms;
                  state_in     = PUMP_OFF;
                  status_in    = STATUS_TARGET_REACHED;
                  mid_add_in   = 1'b1;
               end else begin
                  status_in = STATUS_IRRIGATING;
               end
            end else if (in_cooldown) begin
               state_in  = PUMP_OFF;
               status_in = STATUS_COOLDOWN;
            end else if (in_data_ff.soil_moisture < start_thresh_ff) begin
               running_in = 1'b1;
               start_in   = in_data_ff.now_ms;
               count_in   = count_ff + 1'b1;
               state_in   = PUMP_ON;
               status_in  = STATUS_TRIGGERED;
            end else begin
               state_in  = PUMP_OFF;
               status_in = STATUS_IDLE;
            end
         end
         KIND_MANUAL_ON: begin
            running_in = 1'b1;
            start_in   = in_data_ff.now_ms;
            state_in   = PUMP_ON;
            status_in  = STATUS_MANUAL_ON;
         end
         KIND_MANUAL_OFF: begin
            running_in   = 1'b0;
            last_stop_in = in_data_ff.now_ms;
            state_in     = PUMP_OFF;
            status_in    = STATUS_MANUAL_OFF;
         end
         default: ;
      endcase

      // result fields after the event, volume filled in next stage
      mid_data_in.pin_level       = running_in ^ active_low_ff;
      mid_data_in.pump_running    = running_in;
      mid_data_in.pump_state      = state_in;
      mid_data_in.status_code     = status_in;
      mid_data_in.run_duration_ms = running_in ? (in_data_ff.now_ms - start_in) : '0;
      mid_data_in.session_total   = count_in;
      mid_data_in.dispensed_total = '0;
      mid_prod_in = ProdWidth'(run_ms) * ProdWidth'(flow_rate_ff);
   end

   // saturating volume add
   assign vol_sum = {1'b0, volume_ff} + (VolumeWidth + 1)'(mid_prod_ff);

   always_comb begin
      volume_in = volume_ff;
      if (mid_add_ff) begin
         volume_in = vol_sum[VolumeWidth] ? '1 : vol_sum[VolumeWidth-1:0];
      end
      out_data_in = mid_data_ff;
      out_data_in.dispensed_total = volume_in;
   end

   // control state and pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         start_ff     <= '0;
         last_stop_ff <= '0;
         count_ff     <= '0;
         state_ff     <= PUMP_OFF;
         status_ff    <= STATUS_IDLE;
         volume_ff    <= '0;
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_adv) begin
            running_ff   <= running_in;
            start_ff     <= start_in;
            last_stop_ff <= last_stop_in;
            count_ff     <= count_in;
            state_ff     <= state_in;
            status_ff    <= status_in;
         end
         if (mid_adv) begin
            volume_ff <= volume_in;
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (in_adv) begin
            mid_valid_ff <= 1'b1;
         end else if (mid_adv) begin
            mid_valid_ff <= 1'b0;
         end
         if (mid_adv) begin
            out_valid_ff <= 1'b1;
         end else if (out_free) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (in_adv) begin
         mid_data_ff <= mid_data_in;
         mid_add_ff  <= mid_add_in;
         mid_prod_ff <= mid_prod_in;
      end
      if (mid_adv) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

// ===== verif/tb_irrigation_pump_controller.sv =====
// ----------------------------------------------------------------------------
// tb_irrigation_pump_controller
// Self-checking bench for the pump controller. A table of opening events
// covers the rules and corner cases, partly with hand-written results. Five
// register settings then run random event streams, and a closing burst with
// no idling repeats full-length runs at the highest flow. Each result is compared
// field by field with its hand-written result or an in-bench controller model.
// ----------------------------------------------------------------------------
module tb_irrigation_pump_controller
   import ipc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned OpeningRows  = 26;
   localparam int unsigned NumSettings  = 5;
   localparam int unsigned ItemsPerSet  = 110;
   localparam int unsigned ClosingPairs = 37;
   localparam int unsigned LongHold     = 200;
   localparam int unsigned SettleCycles = 8;

   // one row of the opening table: event, whether a result is written out, result
   typedef struct packed {
      req_type ev;
      logic    typed;
      rsp_type rep;
   } opening_row_type;

   // one register setting plus the time step range used with it
   typedef struct packed {
      logic [31:0] max_run;
      logic [31:0] cooldown;
      logic [9:0]  start_level;
      logic [9:0]  stop_level;
      logic [15:0] flow;
      logic        active_low;
      logic [31:0] span;
   } setting_type;

   // opening events, written for the reset register values
   localparam opening_row_type OpeningEvents [OpeningRows] = '{
      '{'{KIND_UNUSED, 32'd0, 1'b0, 10'd0}, 1'b1,
        '{1'b0, 1'b0, PUMP_OFF, STATUS_IDLE, 32'd0, 32'd0, 64'd0}},
      '{'{KIND_EVALUATE, 32'd5, 1'b0, 10'd0}, 1'b1,
        '{1'b0, 1'b0, PUMP_LOCK, STATUS_RESERVOIR_LOCK, 32'd0, 32'd0, 64'd0}},
      '{'{KIND_EVALUATE, 32'd10, 1'b1, 10'd1000}, 1'b1,
        '{1'b0, 1'b0, PUMP_OFF, STATUS_IDLE, 32'd0, 32'd0, 64'd0}},
      '{'{KIND_EVALUATE, 32'd20, 1'b1, 10'd0}, 1'b1,
        '{1'b1, 1'b1, PUMP_ON, STATUS_TRIGGERED, 32'd0, 32'd1, 64'd0}},
      '{'{KIND_EVALUATE, 32'd1020, 1'b1, 10'd599}, 1'b1,
        '{1'b1, 1'b1, PUMP_ON, STATUS_IRRIGATING, 32'd1000, 32'd1, 64'd0}},
      '{'{KIND_EVALUATE, 32'd2020, 1'b1, 10'd600}, 1'b1,
        '{1'b0, 1'b0, PUMP_OFF, STATUS_TARGET_REACHED, 32'd0, 32'd1, 64'd5120000}},
      '{'{KIND_EVALUATE, 32'd3000, 1'b1, 10'd0}, 1'b1,
        '{1'b0, 1'b0, PUMP_OFF, STATUS_COOLDOWN, 32'd0, 32'd1, 64'd5120000}},
      '{'{KIND_MANUAL_ON, 32'd4000, 1'b1, 10'd0}, 1'b1,
        '{1'b1, 1'b1, PUMP_ON, STATUS_MANUAL_ON, 32'd0, 32'd1, 64'd5120000}},
      '{'{KIND_EVALUATE, 32'd64000, 1'b1, 10'd500}, 1'b1,
        '{1'b0, 1'b0, PUMP_LOCK, STATUS_RUNTIME_LOCK, 32'd0, 32'd1, 64'd158720000}},
      '{'{KIND_MANUAL_OFF, 32'hFFFF_FFFF, 1'b1, 10'd0}, 1'b1,
        '{1'b0, 1'b0, PUMP_OFF, STATUS_MANUAL_OFF, 32'd0, 32'd1, 64'd158720000}},
      '{'{KIND_EVALUATE, 32'd100, 1'b1, 10'd0}, 1'b1,
        '{1'b0, 1'b0, PUMP_OFF, STATUS_COOLDOWN, 32'd0, 32'd1, 64'd158720000}},
      '{'{KIND_EVALUATE, 32'd299999, 1'b1, 10'd399}, 1'b1,
        '{1'b1, 1'b1, PUMP_ON, STATUS_TRIGGERED, 32'd0, 32'd2, 64'd158720000}},
      '{'{KIND_EVALUATE, 32'd300999, 1'b0, 10'd0}, 1'b1,
        '{1'b0, 1'b0, PUMP_LOCK, STATUS_RESERVOIR_LOCK, 32'd0, 32'd2, 64'd158720000}},
      '{'{KIND_MANUAL_ON, 32'hFFFF_FF00, 1'b0, 10'd1023}, 1'b1,
        '{1'b1, 1'b1, PUMP_ON, STATUS_MANUAL_ON, 32'd0, 32'd2, 64'd158720000}},
      '{'{KIND_EVALUATE, 32'h0000_0100, 1'b1, 10'd1023}, 1'b1,
        '{1'b0, 1'b0, PUMP_OFF, STATUS_TARGET_REACHED, 32'd0, 32'd2, 64'd160030720}},
      '{'{KIND_UNUSED, 32'hFFFF_FFFF, 1'b1, 10'd1023}, 1'b1,
        '{1'b0, 1'b0, PUMP_OFF, STATUS_TARGET_REACHED, 32'd0, 32'd2, 64'd160030720}},
      '{'{KIND_EVALUATE, 32'd300256, 1'b1, 10'd0}, 1'b0, '0},
      '{'{KIND_EVALUATE, 32'd360255, 1'b1, 10'd0}, 1'b0, '0},
      '{'{KIND_MANUAL_ON, 32'd400000, 1'b1, 10'd0}, 1'b0, '0},
      '{'{KIND_EVALUATE, 32'd0, 1'b1, 10'd1023}, 1'b0, '0},
      '{'{KIND_MANUAL_OFF, 32'd0, 1'b1, 10'd0}, 1'b0, '0},
      '{'{KIND_EVALUATE, 32'd5, 1'b1, 10'd399}, 1'b0, '0},
      '{'{KIND_MANUAL_OFF, 32'd10, 1'b1, 10'd0}, 1'b0, '0},
      '{'{KIND_UNUSED, 32'h5555_AAAA, 1'b0, 10'h2AA}, 1'b0, '0},
      '{'{KIND_EVALUATE, 32'd20, 1'b0, 10'd0}, 1'b0, '0},
      '{'{KIND_EVALUATE, 32'd30, 1'b1, 10'd0}, 1'b0, '0}
   };

   // register settings for the random part, extremes included
   localparam setting_type Settings [NumSettings] = '{
      '{32'd5000, 32'd2000, 10'd400, 10'd600, 16'd2560, 1'b0, 32'd3000},
      '{32'd0, 32'd0, 10'd0, 10'd0, 16'd0, 1'b1, 32'd50},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1000, 10'd1000, 16'hFFFF, 1'b1,
        32'hFFFF_FFFF},
      '{32'd3000, 32'd10000, 10'd700, 10'd300, 16'd1234, 1'b0, 32'd4000},
      '{32'd60000, 32'd300000, 10'd500, 10'd500, 16'd40000, 1'b1, 32'd100000}
   };

   // longest runs at the highest flow, for the largest volume steps
   localparam setting_type ClosingSetting =
      '{32'hFFFF_FFFF, 32'd0, 10'd0, 10'd0, 16'hFFFF, 1'b0, 32'd0};

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [CsrDatWidth-1:0] csr_wdata = '0;

   // controller model: registers
   logic [31:0] cfg_max_run;
   logic [31:0] cfg_cooldown;
   logic [9:0]  cfg_start_level;
   logic [9:0]  cfg_stop_level;
   logic [15:0] cfg_flow;
   logic        cfg_active_low;

   // controller model: state
   logic           pump_on;
   logic [31:0]    run_start_ms;
   logic [31:0]    stop_ms;
   logic [31:0]    sessions;
   logic [63:0]    volume_total;
   pump_state_type state_now;
   status_type     status_now;

   rsp_type     expected_reports [$];
   rsp_type     oldest_report;
   int unsigned mismatch_count = 0;
   logic [31:0] sim_ms = '0;
   bit          tx_idle_on = 1'b1;
   bit          rx_idle_on = 1'b1;
   bit          hold_results_req = 1'b0;

   irrigation_pump_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // exact run time times flow, clamped at the top of 64 bits
   function automatic void add_volume(input logic [31:0] run_ms);
      logic [64:0] sum;
      sum = {1'b0, volume_total} + ({33'd0, run_ms} * {49'd0, cfg_flow});
      volume_total = sum[64] ? '1 : sum[63:0];
   endfunction

   // apply one event to the model and return the report it produces
   function automatic rsp_type pump_report_after(input req_type ev);
      logic [31:0] run_ms;
      logic [31:0] rest_ms;
      rsp_type     rep;
      run_ms  = ev.now_ms - run_start_ms;
      rest_ms = ev.now_ms - stop_ms;
      case (kind_type'(ev.kind))
         KIND_EVALUATE: begin
            if (!ev.reservoir_safe) begin
               if (pump_on) begin
                  pump_on = 1'b0;
                  stop_ms = ev.now_ms;
               end
               state_now  = PUMP_LOCK;
               status_now = STATUS_RESERVOIR_LOCK;
            end else if (pump_on) begin
               // running session: runtime limit first, then moisture target
               if (run_ms >= cfg_max_run) begin
                  pump_on    = 1'b0;
                  stop_ms    = ev.now_ms;
                  state_now  = PUMP_LOCK;
                  status_now = STATUS_RUNTIME_LOCK;
                  add_volume(run_ms);
               end else if (ev.soil_moisture >= cfg_stop_level) begin
                  pump_on    = 1'b0;
                  stop_ms    = ev.now_ms;
                  state_now  = PUMP_OFF;
                  status_now = STATUS_TARGET_REACHED;
                  add_volume(run_ms);
               end else begin
                  status_now = STATUS_IRRIGATING;
               end
            end else if (rest_ms < cfg_cooldown && stop_ms != 32'd0) begin
               state_now  = PUMP_OFF;
               status_now = STATUS_COOLDOWN;
            end else if (ev.soil_moisture < cfg_start_level) begin
               pump_on      = 1'b1;
               run_start_ms = ev.now_ms;
               sessions     = sessions + 32'd1;
               state_now    = PUMP_ON;
               status_now   = STATUS_TRIGGERED;
            end else begin
               state_now  = PUMP_OFF;
               status_now = STATUS_IDLE;
            end
         end
         KIND_MANUAL_ON: begin
            pump_on      = 1'b1;
            run_start_ms = ev.now_ms;
            state_now    = PUMP_ON;
            status_now   = STATUS_MANUAL_ON;
         end
         KIND_MANUAL_OFF: begin
            pump_on    = 1'b0;
            stop_ms    = ev.now_ms;
            state_now  = PUMP_OFF;
            status_now = STATUS_MANUAL_OFF;
         end
         default: begin
         end
      endcase
      rep.pin_level       = pump_on ^ cfg_active_low;
      rep.pump_running    = pump_on;
      rep.pump_state      = state_now;
      rep.status_code     = status_now;
      rep.run_duration_ms = pump_on ? ev.now_ms - run_start_ms : 32'd0;
      rep.session_total   = sessions;
      rep.dispensed_total = volume_total;
      return rep;
   endfunction

   // random event: time mostly steps forward, moisture clusters near thresholds
   function automatic req_type random_event(input logic [31:0] span);
      req_type     ev;
      int unsigned roll;
      int          level;
      if ($urandom_range(0, 19) == 0) begin
         sim_ms = $urandom();
      end else begin
         sim_ms = sim_ms + $urandom_range(0, span);
      end
      roll    = $urandom_range(0, 99);
      ev.kind = (roll < 76) ? KIND_EVALUATE :
                (roll < 86) ? KIND_MANUAL_ON :
                (roll < 96) ? KIND_MANUAL_OFF : KIND_UNUSED;
      ev.now_ms         = sim_ms;
      ev.reservoir_safe = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 2) == 0) begin
         level = $urandom_range(0, 1023);
      end else begin
         level = ($urandom_range(0, 1) != 0) ? int'(cfg_start_level) : int'(cfg_stop_level);
         level = level + int'($urandom_range(0, 6)) - 3;
         if (level < 0) level = 0;
         if (level > 1023) level = 1023;
      end
      ev.soil_moisture = level[9:0];
      return ev;
   endfunction

   // offer one item, wait for it to be taken, then record what it must produce
   task automatic offer_event(input req_type ev, input logic typed, input rsp_type typed_rep);
      rsp_type predicted;
      if (tx_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(posedge clock); while (req_stall);
      predicted = pump_report_after(ev);
      expected_reports.push_back(typed ? typed_rep : predicted);
   endtask

   // stop sending until every outstanding result is back
   task automatic await_all_reports();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   // register write, mirrored into the model
   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_MAX_RUN_MS:      cfg_max_run     = value;
         CSR_MIN_COOLDOWN_MS: cfg_cooldown    = value;
         CSR_START_THRESHOLD: cfg_start_level = value[9:0];
         CSR_STOP_THRESHOLD:  cfg_stop_level  = value[9:0];
         CSR_FLOW_RATE:       cfg_flow        = value[15:0];
         CSR_ACTIVE_LOW:      cfg_active_low  = value[0];
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   // all six registers, written only once the block has gone quiet
   task automatic load_settings(input setting_type s);
      await_all_reports();
      repeat (SettleCycles) @(posedge clock);
      write_reg(CSR_MAX_RUN_MS, s.max_run);
      write_reg(CSR_MIN_COOLDOWN_MS, s.cooldown);
      write_reg(CSR_START_THRESHOLD, {22'd0, s.start_level});
      write_reg(CSR_STOP_THRESHOLD, {22'd0, s.stop_level});
      write_reg(CSR_FLOW_RATE, {16'd0, s.flow});
      write_reg(CSR_ACTIVE_LOW, {31'd0, s.active_low});
      csr_wr_en <= 1'b0;
   endtask

   function automatic void note_field(input string name, input logic [63:0] want_v,
                                      input logic [63:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, actual %0d", name, want_v, got_v);
         mismatch_count++;
      end
   endfunction

   // result side: random stall bursts, plus one long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_results_req) begin
            hold_results_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LongHold) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare every accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            $error("unexpected result item: status_code %0d", rsp_data.status_code);
            mismatch_count++;
         end else begin
            oldest_report = expected_reports.pop_front();
            note_field("pin_level", oldest_report.pin_level, rsp_data.pin_level);
            note_field("pump_running", oldest_report.pump_running, rsp_data.pump_running);
            note_field("pump_state", oldest_report.pump_state, rsp_data.pump_state);
            note_field("status_code", oldest_report.status_code, rsp_data.status_code);
            note_field("run_duration_ms", oldest_report.run_duration_ms,
                       rsp_data.run_duration_ms);
            note_field("session_total", oldest_report.session_total,
                       rsp_data.session_total);
            note_field("dispensed_total", oldest_report.dispensed_total,
                       rsp_data.dispensed_total);
         end
      end
   end

   // run limit
   initial begin
      #20_000_000;
      $display("tb_irrigation_pump_controller: FAIL");
      $finish;
   end

   // main sequence
   initial begin
      cfg_max_run     = MaxRunReset;
      cfg_cooldown    = MinCooldownReset;
      cfg_start_level = StartThreshReset;
      cfg_stop_level  = StopThreshReset;
      cfg_flow        = FlowRateReset;
      cfg_active_low  = ActiveLowReset;
      pump_on         = 1'b0;
      run_start_ms    = '0;
      stop_ms         = '0;
      sessions        = '0;
      volume_total    = '0;
      state_now       = PUMP_OFF;
      status_now      = STATUS_IDLE;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // opening table at reset register values
      for (int r = 0; r < OpeningRows; r++) begin
         offer_event(OpeningEvents[r].ev, OpeningEvents[r].typed, OpeningEvents[r].rep);
      end

      // random streams under each setting
      for (int p = 0; p < NumSettings; p++) begin
         load_settings(Settings[p]);
         for (int i = 0; i < ItemsPerSet; i++) begin
            if (i % 32 == 0) begin
               tx_idle_on = ($urandom_range(0, 3) != 0);
               rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            // long result hold while items keep coming, so the input backs up
            if (p == 0 && i == 40) begin
               hold_results_req = 1'b1;
               tx_idle_on       = 1'b0;
            end
            if (p == 2 && i == 60) begin
               await_all_reports();
            end
            offer_event(random_event(Settings[p].span), 1'b0, '0);
         end
      end

      // closing burst with no idling: full-length runs at the highest flow
      load_settings(ClosingSetting);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      for (int k = 0; k < ClosingPairs; k++) begin
         offer_event('{KIND_MANUAL_ON, 32'd1, 1'b1, 10'd0}, 1'b0, '0);
         offer_event('{KIND_EVALUATE, 32'd0, 1'b1, 10'd0}, 1'b0, '0);
      end

      await_all_reports();
      repeat (SettleCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_irrigation_pump_controller: PASS");
      end else begin
         $display("tb_irrigation_pump_controller: FAIL");
      end
      $finish;
   end

endmodule
